// File: rtl/subsequence_count_range_query_assert.svh
// Assertion macros used by the checker of the range query block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef SUBSEQUENCE_COUNT_RANGE_QUERY_ASSERT_SVH
`define SUBSEQUENCE_COUNT_RANGE_QUERY_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCRQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrq assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SCRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrq assertion failed");

// Same as the next-cycle check, but also active while reset is asserted.
`define SCRQ_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("scrq assertion failed");

`endif

// File: rtl/scrq_pkg.sv
// Shared constants and modular arithmetic helpers for the range query block.
// Depends on nothing; the multiplier and the top level refer to it by scoped names.
package scrq_pkg;

    localparam int ElemW = 30;
    localparam logic [ElemW-1:0] ModP = 30'd1000000007;
    localparam logic [30:0] BarrettM = 31'd1152921496;
    localparam int DefMaxLen = 4096;
    localparam int DefAlphabet = 9;

    typedef logic [ElemW-1:0] t_elem;

    function automatic t_elem mod_add(input t_elem a, input t_elem b);
        logic [ElemW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, ModP}) begin
                s = s - {1'b0, ModP};
            end
            mod_add = s[ElemW-1:0];
        end
    endfunction

    function automatic t_elem mod_sub(input t_elem a, input t_elem b);
        logic [ElemW:0] s;
        begin
            if (a >= b) begin
                s = {1'b0, a} - {1'b0, b};
            end else begin
                s = {1'b0, a} + {1'b0, ModP} - {1'b0, b};
            end
            mod_sub = s[ElemW-1:0];
        end
    endfunction

endpackage

// File: rtl/scrq_if.sv
// Valid/ready channel interfaces for the request and result items.
// Depends on nothing.
interface scrq_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  symbol;
    logic [12:0] left_pos;
    logic [12:0] right_pos;
    modport source (output valid, kind, symbol, left_pos, right_pos, input ready);
    modport sink (input valid, kind, symbol, left_pos, right_pos, output ready);
endinterface

interface scrq_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] count;
    logic        range_error;
    modport source (output valid, count, range_error, input ready);
    modport sink (input valid, count, range_error, output ready);
endinterface

// File: rtl/scrq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module scrq_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/scrq_modmul.sv
// Four-stage pipelined modular multiplier using Barrett reduction.
// Depends on scrq_pkg.
module scrq_modmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  scrq_pkg::t_elem    i_a,
    input  scrq_pkg::t_elem    i_b,
    output logic               o_valid,
    output scrq_pkg::t_elem    o_res
);
    logic [59:0] r_p1, r_p2;
    logic [61:0] r_q2;
    logic [31:0] r_r3;
    logic [31:0] n_r3;
    logic [31:0] n_t1, n_t2;
    logic [3:0]  r_v;
    scrq_pkg::t_elem r_res;

    always_comb begin
        n_r3 = r_p2[31:0] - (32'(r_q2[61:31]) * {2'b0, scrq_pkg::ModP});
        n_t1 = (r_r3 >= {2'b0, scrq_pkg::ModP}) ? r_r3 - {2'b0, scrq_pkg::ModP} : r_r3;
        n_t2 = (n_t1 >= {2'b0, scrq_pkg::ModP}) ? n_t1 - {2'b0, scrq_pkg::ModP} : n_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
        r_p1  <= {30'b0, i_a} * {30'b0, i_b};
        r_q2  <= {31'b0, r_p1[59:29]} * {31'b0, scrq_pkg::BarrettM};
        r_p2  <= r_p1;
        r_r3  <= n_r3;
        r_res <= n_t2[29:0];
    end

    assign o_valid = r_v[3];
    assign o_res   = r_res;
endmodule

// File: rtl/subsequence_count_range_query.sv
// Top level of the distinct-subsequence range query block.
// Depends on scrq_pkg, scrq_if, scrq_ram and scrq_modmul.
//
// Usage: requests arrive on i_in, one item per valid/ready handshake. An item
// with kind 0 appends a symbol: a table read, then the read-modify-write of
// the row, table and tag state. It gives no result. Appends with a bad
// symbol or on a full store are dropped. An item with kind 1 is a range
// query, and it gives one result item on o_out. The single shared four-stage
// modular multiplier works a valid query by walking the lanes of the two rows
// read from the prefix row memories. The next item can be accepted in the same
// cycle as the result shows. A malformed query gives count 0 with range_error
// set. One item is worked on at a time, and i_in.ready is high when the block
// is idle. The result register lets a new item be accepted while a result
// waits. A query that finishes while the receiver stalls holds until the
// register frees up. Reset empties the store and restores the tables at once.
module subsequence_count_range_query #(
    parameter int MAX_LEN  = scrq_pkg::DefMaxLen,
    parameter int ALPHABET = scrq_pkg::DefAlphabet
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scrq_in_if.sink     i_in,
    scrq_out_if.source  o_out
);
    localparam int Lanes = ALPHABET + 1;
    localparam int LaneW = Lanes * scrq_pkg::ElemW;
    localparam int LenW  = $clog2(MAX_LEN + 1);
    localparam int LiW   = $clog2(Lanes);
    localparam int LcW   = $clog2(Lanes + 1);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StUpd  = 2'd1;
    localparam logic [1:0] StRun  = 2'd2;
    localparam logic [1:0] StFin  = 2'd3;

    typedef logic [Lanes-1:0][scrq_pkg::ElemW-1:0] t_row;

    logic [1:0]      r_st, n_st;
    logic [LenW-1:0] r_len;
    t_row            r_lastf;
    t_row            r_tag;
    logic [Lanes-1:0] r_fv, r_bv;
    logic [LiW-1:0]  r_c;
    logic            r_b0;
    logic            r_qerr;
    logic [LcW-1:0]  r_k, r_nres;
    scrq_pkg::t_elem r_acc;
    logic            r_ovalid;
    scrq_pkg::t_elem r_count;
    logic            r_err;

    logic            acc_in, drop, bad_q;
    logic [LiW-1:0]  sym_c;
    t_row            frow_rd, brow_rd, ft_rd, bt_rd;
    t_row            n_f, n_b, n_tag, n_bt;
    logic            row_we, mm_valid, mm_ovalid, out_free;
    scrq_pkg::t_elem mm_a, mm_b, mm_res, fj, bj;

    assign out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_st == StIdle);
    assign acc_in = i_in.valid && i_in.ready;
    assign sym_c = LiW'(32'(i_in.symbol) + 32'd1);
    assign drop = (32'(r_len) >= MAX_LEN) || (32'(i_in.symbol) >= ALPHABET);
    assign bad_q = (32'(i_in.right_pos) > 32'(r_len)) || (i_in.left_pos == 13'd0)
                   || (i_in.left_pos > i_in.right_pos);
    assign row_we = (r_st == StUpd);

    scrq_ram #(.W(LaneW), .D(MAX_LEN + 1)) u_fwd_rows (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(LenW'(r_len + 1'b1)), .i_wdata(n_f),
        .i_re(acc_in && i_in.kind), .i_raddr(LenW'(i_in.right_pos)), .o_rdata(frow_rd)
    );

    scrq_ram #(.W(LaneW), .D(MAX_LEN + 1)) u_bwd_rows (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(LenW'(r_len + 1'b1)), .i_wdata(n_b),
        .i_re(acc_in && i_in.kind), .i_raddr(LenW'(i_in.left_pos - 13'd1)),
        .o_rdata(brow_rd)
    );

    scrq_ram #(.W(LaneW), .D(Lanes)) u_fwd_last (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(r_c), .i_wdata(r_lastf),
        .i_re(acc_in && !i_in.kind), .i_raddr(sym_c), .o_rdata(ft_rd)
    );

    scrq_ram #(.W(LaneW), .D(Lanes)) u_bwd_tab (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(r_c), .i_wdata(n_bt),
        .i_re(acc_in && !i_in.kind), .i_raddr(sym_c), .o_rdata(bt_rd)
    );

    always_comb begin
        scrq_pkg::t_elem fc, bo, unit;
        for (int j = 0; j < Lanes; j++) begin
            unit = (LiW'(j) == r_c) ? 30'd1 : 30'd0;
            fc = r_fv[r_c] ? ft_rd[j] : unit;
            bo = r_bv[r_c] ? bt_rd[j] : unit;
            n_f[j]   = scrq_pkg::mod_sub(scrq_pkg::mod_add(r_lastf[j], r_lastf[j]), fc);
            n_tag[j] = scrq_pkg::mod_sub(30'd0, bo);
            n_bt[j]  = scrq_pkg::mod_add(scrq_pkg::mod_add(bo, bo), r_tag[j]);
            n_b[j]   = scrq_pkg::mod_add((j == 0) ? 30'd1 : 30'd0, n_tag[j]);
        end
    end

    always_comb begin
        fj = frow_rd[r_k[LiW-1:0]];
        bj = brow_rd[r_k[LiW-1:0]];
        mm_a = fj;
        if (r_b0) begin
            mm_b = (r_k == '0) ? 30'd1 : 30'd0;
        end else begin
            mm_b = bj;
        end
        mm_valid = (r_st == StRun) && (32'(r_k) < Lanes);
    end

    scrq_modmul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(mm_valid), .i_a(mm_a), .i_b(mm_b),
        .o_valid(mm_ovalid), .o_res(mm_res)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            StIdle: begin
                if (acc_in) begin
                    if (i_in.kind) begin
                        n_st = bad_q ? StFin : StRun;
                    end else if (!drop) begin
                        n_st = StUpd;
                    end
                end
            end
            StUpd: begin
                n_st = StIdle;
            end
            StRun: begin
                if (mm_ovalid && (32'(r_nres) == Lanes - 1)) begin
                    n_st = StFin;
                end
            end
            StFin: begin
                if (out_free) begin
                    n_st = StIdle;
                end
            end
            default: begin
                n_st = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= StIdle;
            r_len    <= '0;
            r_fv     <= '0;
            r_bv     <= '0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_nres   <= '0;
            for (int j = 0; j < Lanes; j++) begin
                r_lastf[j] <= 30'd1;
                r_tag[j]   <= 30'd0;
            end
        end else begin
            r_st <= n_st;
            if (acc_in) begin
                r_c    <= sym_c;
                r_b0   <= (i_in.left_pos == 13'd1);
                r_qerr <= bad_q;
                r_acc  <= '0;
                r_k    <= '0;
                r_nres <= '0;
            end
            if (row_we) begin
                r_len      <= LenW'(r_len + 1'b1);
                r_lastf    <= n_f;
                r_tag      <= n_tag;
                r_fv[r_c]  <= 1'b1;
                r_bv[r_c]  <= 1'b1;
            end
            if (mm_valid) begin
                r_k <= LcW'(r_k + 1'b1);
            end
            if (mm_ovalid) begin
                r_acc  <= scrq_pkg::mod_add(r_acc, mm_res);
                r_nres <= LcW'(r_nres + 1'b1);
            end
            if (r_st == StFin && out_free) begin
                r_ovalid <= 1'b1;
                r_count  <= r_qerr ? 30'd0 : scrq_pkg::mod_sub(r_acc, 30'd1);
                r_err    <= r_qerr;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.count       = r_count;
    assign o_out.range_error = r_err;
endmodule

// File: rtl/scrq_checker.sv
// Port-level checker for the range query block, bound to the top level.
// Depends on subsequence_count_range_query_assert.svh.
`include "subsequence_count_range_query_assert.svh"

module scrq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_kind,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [29:0] i_out_count,
    input logic        i_out_error
);
    `SCRQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_count))
    `SCRQ_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, i_out_valid && i_out_error, i_out_count == 30'd0)
    `SCRQ_ASSERT_SAME(a_in_range, i_clk, i_rst_n, i_out_valid, i_out_count < 30'd1000000007)
    `SCRQ_ASSERT_NEXT(a_append_quiet, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_kind, !$rose(i_out_valid))
    `SCRQ_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind subsequence_count_range_query scrq_checker u_scrq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready), .i_in_kind(i_in.kind),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_count(o_out.count), .i_out_error(o_out.range_error)
);
